>>> src/assert_macros.svh
// Assertion macros used by the checker file of the cipher block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the given reset is high.
`define SFE_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked through reset as well.
`define SFE_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sfe_pkg.sv
// Types, constants and round-function helpers for the Feistel cipher block.
// No dependencies; used by every module of the block.
`default_nettype none

package sfe_pkg;

   localparam int BLOCK_W   = 32;
   localparam int HALF_W    = 16;
   localparam int KEY_DEPTH = 32;
   localparam int KEY_IDX_W = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [0:0] {
      CMD_LOAD    = 1'b0,
      CMD_ENCRYPT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [BLOCK_W-1:0]   data;   // load: {idx, key} in low bits; encrypt: block
   } q_entry_type;

   typedef struct packed {
      logic        push;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic        full;
      logic        empty;
   } q_status_type;

   localparam logic [3:0] SBOX [16] = '{
      4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   // Output bit j (MSB first) takes input bit PERM[j] (MSB first).
   localparam logic [3:0] PERM [16] = '{
      4'd7, 4'd13, 4'd1, 4'd8, 4'd11, 4'd14, 4'd2, 4'd5,
      4'd4, 4'd10, 4'd15, 4'd0, 4'd3, 4'd6, 4'd9, 4'd12
   };

   function automatic logic [HALF_W-1:0] sub16(input logic [HALF_W-1:0] v);
      logic [HALF_W-1:0] r;
      r = '0;
      for (int n = 0; n < HALF_W / 4; n++) begin
         r[4*n +: 4] = SBOX[v[4*n +: 4]];
      end
      return r;
   endfunction

   function automatic logic [HALF_W-1:0] perm16(input logic [HALF_W-1:0] v);
      logic [HALF_W-1:0] r;
      r = '0;
      for (int j = 0; j < HALF_W; j++) begin
         r[HALF_W-1-j] = v[4'(HALF_W-1) - PERM[j]];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/sfe_front.sv
// Front end: takes request transfers, classifies them and packs queue entries.
// Depends on sfe_pkg.
`default_nettype none

module sfe_front (
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [sfe_pkg::KEY_IDX_W-1:0]     req_key_index,
   input  wire logic [sfe_pkg::HALF_W-1:0]        req_key_value,
   input  wire logic [sfe_pkg::BLOCK_W-1:0]       req_plain_block,
   input  wire sfe_pkg::q_status_type             q_status,
   output sfe_pkg::q_push_type                    q_push
);

   sfe_pkg::cmd_type cmd;

   always_comb begin
      cmd       = sfe_pkg::cmd_type'(req_command);
      req_ready = !q_status.full;

      q_push.push       = req_valid && !q_status.full;
      q_push.entry.cmd  = cmd;
      q_push.entry.data = '0;
      unique case (cmd)
         sfe_pkg::CMD_LOAD: begin
            q_push.entry.data[sfe_pkg::HALF_W-1:0] = req_key_value;
            q_push.entry.data[sfe_pkg::KEY_IDX_W+sfe_pkg::HALF_W-1:sfe_pkg::HALF_W] =
               req_key_index;
         end
         sfe_pkg::CMD_ENCRYPT: begin
            q_push.entry.data = req_plain_block;
         end
         default: begin
            q_push.entry.data = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/sfe_queue.sv
// Short FIFO between the front end and the round engine.
// Depends on sfe_pkg.
`default_nettype none

module sfe_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfe_pkg::q_push_type   q_push,
   input  wire logic                  q_pop,
   output sfe_pkg::q_status_type      q_status,
   output sfe_pkg::q_entry_type       q_head
);

   localparam int PTR_W = (sfe_pkg::QUEUE_DEPTH > 1) ? $clog2(sfe_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(sfe_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(sfe_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(sfe_pkg::QUEUE_DEPTH - 1);

   sfe_pkg::q_entry_type slot_ff [sfe_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;
   logic                 do_push, do_pop;

   always_comb begin
      q_status.full  = (count_ff == FULL_CNT);
      q_status.empty = (count_ff == '0);
      q_head         = slot_ff[rd_ptr_ff];

      do_push = q_push.push && !q_status.full;
      do_pop  = q_pop && !q_status.empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

`default_nettype wire

>>> src/sfe_back.sv
// Back end: round-key store, one shared round unit and the result register.
// Depends on sfe_pkg.
`default_nettype none

module sfe_back #(
   parameter int ROUNDS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sfe_pkg::q_status_type            q_status,
   input  wire sfe_pkg::q_entry_type             q_head,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [sfe_pkg::BLOCK_W-1:0]           rsp_cipher_block
);

   localparam int HW = sfe_pkg::HALF_W;
   localparam int IW = sfe_pkg::KEY_IDX_W;
   localparam logic [IW-1:0] LAST_ROUND = IW'(ROUNDS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        round_ff, round_in;
   logic [HW-1:0]        left_ff, left_in;
   logic [HW-1:0]        right_ff, right_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [sfe_pkg::BLOCK_W-1:0] rsp_data_ff, rsp_data_in;

   logic [HW-1:0]        key_store [sfe_pkg::KEY_DEPTH];
   logic [HW-1:0]        key_rd_ff;
   logic [IW-1:0]        key_rd_addr;
   logic                 key_wr;
   logic [IW-1:0]        key_wr_addr;
   logic [HW-1:0]        key_wr_data;
   logic [HW-1:0]        f_val;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cipher_block = rsp_data_ff;

   always_comb begin
      q_pop       = (state_ff == ST_IDLE) && !q_status.empty;
      key_wr      = q_pop && (q_head.cmd == sfe_pkg::CMD_LOAD);
      key_wr_addr = q_head.data[IW+HW-1:HW];
      key_wr_data = q_head.data[HW-1:0];
      // prefetch: key for round 0 at start, then the following round's key
      key_rd_addr = (state_ff == ST_IDLE) ? '0 : round_ff + 1'b1;
      f_val       = sfe_pkg::perm16(sfe_pkg::sub16(key_rd_ff ^ right_ff));

      state_in     = state_ff;
      round_in     = round_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop && (q_head.cmd == sfe_pkg::CMD_ENCRYPT)) begin
               left_in  = q_head.data[2*HW-1:HW];
               right_in = q_head.data[HW-1:0];
               round_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            left_in  = right_ff;
            right_in = left_ff ^ f_val;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FLUSH;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {left_ff, right_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      round_ff    <= round_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_store[key_wr_addr] <= key_wr_data;
      end
      key_rd_ff <= key_store[key_rd_addr];
   end

endmodule

`default_nettype wire

>>> src/slim_feistel_encrypt.sv
// Encrypt: a request is queued, popped in ST_IDLE, run through ROUNDS rounds in ST_RUN
// by the single round unit at one round per cycle, and loaded into the result register in
// ST_FLUSH once it is free; a new block is taken only after that. Key loads drain at one
// per cycle while the sequencer is idle. Reset clears the queue, the round sequencer
// and the result valid; the key store is not cleared and must be loaded first.
// Top level of the Feistel cipher; depends on sfe_pkg, sfe_front, sfe_queue, sfe_back.
`default_nettype none

module slim_feistel_encrypt #(
   parameter int ROUNDS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [sfe_pkg::KEY_IDX_W-1:0]     req_key_index,
   input  wire logic [sfe_pkg::HALF_W-1:0]        req_key_value,
   input  wire logic [sfe_pkg::BLOCK_W-1:0]       req_plain_block,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [sfe_pkg::BLOCK_W-1:0]            rsp_cipher_block
);

   sfe_pkg::q_push_type   q_push;
   sfe_pkg::q_status_type q_status;
   sfe_pkg::q_entry_type  q_head;
   logic                  q_pop;

   sfe_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_key_index   (req_key_index),
      .req_key_value   (req_key_value),
      .req_plain_block (req_plain_block),
      .q_status        (q_status),
      .q_push          (q_push)
   );

   sfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   sfe_back #(
      .ROUNDS (ROUNDS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cipher_block (rsp_cipher_block)
   );

endmodule

`default_nettype wire

>>> src/sfe_checker.sv
// Port-level checks for the Feistel cipher, bound onto the top level.
// Depends on assert_macros.svh and sfe_pkg.
`default_nettype none
`include "assert_macros.svh"

module sfe_checker #(
   parameter int ROUNDS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [sfe_pkg::BLOCK_W-1:0]   rsp_cipher_block
);

   `SFE_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped before transfer")
   `SFE_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_cipher_block), "rsp payload changed while stalled")
   `SFE_ASSERT(a_rst_clears, clock, $past(reset) |-> !rsp_valid, "result valid after reset")
   `SFE_ASSERT(a_min_latency, clock, $rose(rsp_valid) |-> !$past(reset, ROUNDS + 2), "result sooner than all rounds allow")

endmodule

bind slim_feistel_encrypt sfe_checker #(
   .ROUNDS (ROUNDS)
) u_sfe_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_cipher_block (rsp_cipher_block)
);

`default_nettype wire
